>>> design/swsfd_pkg.sv
// Constants for the sync-word sensor frame deframer.
// No dependencies; used by the deframer core.
package swsfd_pkg;

    localparam int FRAME_BYTES = 34;
    localparam int CNT_W       = 6;
    localparam int IDX_W       = 4;
    localparam int VAL_W       = 16;

    localparam logic [7:0] SYNC_HEAD   = 8'h53;
    localparam logic [7:0] SYNC_SECOND = 8'h54;
    localparam logic [7:0] SYNC_END1   = 8'h45;
    localparam logic [7:0] SYNC_END2   = 8'h4E;

    localparam logic [CNT_W-1:0] POS_SECOND = CNT_W'(1);
    localparam logic [CNT_W-1:0] POS_END1   = CNT_W'(FRAME_BYTES - 2);
    localparam logic [CNT_W-1:0] POS_END2   = CNT_W'(FRAME_BYTES - 1);
    localparam logic [CNT_W-1:0] POS_DATA   = CNT_W'(2);
    localparam logic [CNT_W-1:0] POS_MODE   = CNT_W'(30);

    localparam logic [IDX_W-1:0] LAST_DATA_WORD = IDX_W'(13);
    localparam logic [IDX_W-1:0] MODE_WORD      = IDX_W'(14);

endpackage

>>> design/swsfd_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module swsfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 34
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> design/sync_word_sensor_frame_deframer_core.sv
// Sync-word sensor frame deframer: hunts for 'S', stores the rest of a 34-byte frame in a RAM
// and replays a good frame as 15 result transactions. Depends on swsfd_pkg and swsfd_ram.
// Input takes one byte per cycle while hunting or collecting. After a good frame it is stalled
// for the replay: each data word is read as its low byte, then its high byte, then offered;
// the mode byte is read, then offered. The first word is offered after RDLO, RDHI and WAIT.
// Reset clears the counter, check flags, sequencer and output valid; the RAM is not cleared.
module sync_word_sensor_frame_deframer_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         rx_valid,
    output logic                         rx_stall,
    input  logic [7:0]                   rx_byte,
    output logic                         word_valid,
    input  logic                         word_stall,
    output logic [swsfd_pkg::IDX_W-1:0]  word_index,
    output logic [swsfd_pkg::VAL_W-1:0]  word_value,
    output logic                         last_word
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_RDLO   = 3'd1;
    localparam logic [2:0] ST_RDHI   = 3'd2;
    localparam logic [2:0] ST_WAIT   = 3'd3;
    localparam logic [2:0] ST_RDMODE = 3'd4;
    localparam logic [2:0] ST_MODEW  = 3'd5;

    logic [2:0]                        state_reg, state_next;
    logic [swsfd_pkg::CNT_W-1:0]       bytes_held_reg, bytes_held_next;
    logic                              second_ok_reg, second_ok_next;
    logic                              end1_ok_reg, end1_ok_next;
    logic [swsfd_pkg::IDX_W-1:0]       word_k_reg, word_k_next;
    logic [7:0]                        lo_reg, lo_next;
    logic                              word_valid_reg, word_valid_next;
    logic [swsfd_pkg::IDX_W-1:0]       word_index_reg, word_index_next;
    logic [swsfd_pkg::VAL_W-1:0]       word_value_reg, word_value_next;
    logic                              last_word_reg, last_word_next;

    logic                              rx_take;
    logic                              slot_free;
    logic                              ram_wr_en;
    logic                              ram_rd_en;
    logic [swsfd_pkg::CNT_W-1:0]       ram_rd_addr;
    logic [7:0]                        ram_rd_data;
    logic [swsfd_pkg::CNT_W-1:0]       lo_addr;

    assign rx_stall  = (state_reg != ST_IDLE);
    assign rx_take   = rx_valid && !rx_stall;
    assign slot_free = !word_valid_reg || !word_stall;
    assign lo_addr   = {1'b0, word_k_reg, 1'b0} + swsfd_pkg::POS_DATA;

    // Byte 0 is always 'S' and is never read back, so only the collecting bytes are stored.
    assign ram_wr_en = rx_take && (bytes_held_reg != '0);

    swsfd_ram #(
        .WIDTH (8),
        .DEPTH (swsfd_pkg::FRAME_BYTES)
    ) u_frame_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (bytes_held_reg),
        .wr_data (rx_byte),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    always_comb
    begin
        state_next      = state_reg;
        bytes_held_next = bytes_held_reg;
        second_ok_next  = second_ok_reg;
        end1_ok_next    = end1_ok_reg;
        word_k_next     = word_k_reg;
        lo_next         = lo_reg;
        word_valid_next = word_valid_reg && word_stall;
        word_index_next = word_index_reg;
        word_value_next = word_value_reg;
        last_word_next  = last_word_reg;
        ram_rd_en       = 1'b0;
        ram_rd_addr     = lo_addr;

        case (state_reg)
            ST_IDLE:
            begin
                if (rx_take)
                begin
                    if (bytes_held_reg == '0)
                    begin
                        if (rx_byte == swsfd_pkg::SYNC_HEAD)
                        begin
                            bytes_held_next = swsfd_pkg::CNT_W'(1);
                        end
                    end
                    else if (bytes_held_reg == swsfd_pkg::POS_END2)
                    begin
                        bytes_held_next = '0;
                        word_k_next     = '0;
                        if (second_ok_reg && end1_ok_reg &&
                            rx_byte == swsfd_pkg::SYNC_END2)
                        begin
                            state_next = ST_RDLO;
                        end
                    end
                    else
                    begin
                        bytes_held_next = bytes_held_reg + swsfd_pkg::CNT_W'(1);
                        if (bytes_held_reg == swsfd_pkg::POS_SECOND)
                        begin
                            second_ok_next = (rx_byte == swsfd_pkg::SYNC_SECOND);
                        end
                        if (bytes_held_reg == swsfd_pkg::POS_END1)
                        begin
                            end1_ok_next = (rx_byte == swsfd_pkg::SYNC_END1);
                        end
                    end
                end
            end
            ST_RDLO:
            begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = lo_addr;
                state_next  = ST_RDHI;
            end
            ST_RDHI:
            begin
                lo_next     = ram_rd_data;
                ram_rd_en   = 1'b1;
                ram_rd_addr = lo_addr + swsfd_pkg::CNT_W'(1);
                state_next  = ST_WAIT;
            end
            ST_WAIT:
            begin
                // The high byte stays in the RAM read register until the slot frees.
                if (slot_free)
                begin
                    word_valid_next = 1'b1;
                    word_index_next = word_k_reg;
                    word_value_next = {ram_rd_data, lo_reg};
                    last_word_next  = 1'b0;
                    word_k_next     = word_k_reg + swsfd_pkg::IDX_W'(1);
                    if (word_k_reg == swsfd_pkg::LAST_DATA_WORD)
                    begin
                        state_next = ST_RDMODE;
                    end
                    else
                    begin
                        state_next = ST_RDLO;
                    end
                end
            end
            ST_RDMODE:
            begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = swsfd_pkg::POS_MODE;
                state_next  = ST_MODEW;
            end
            ST_MODEW:
            begin
                if (slot_free)
                begin
                    word_valid_next = 1'b1;
                    word_index_next = swsfd_pkg::MODE_WORD;
                    word_value_next = {8'h00, ram_rd_data};
                    last_word_next  = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            bytes_held_reg <= '0;
            second_ok_reg  <= 1'b0;
            end1_ok_reg    <= 1'b0;
            word_k_reg     <= '0;
            word_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            bytes_held_reg <= bytes_held_next;
            second_ok_reg  <= second_ok_next;
            end1_ok_reg    <= end1_ok_next;
            word_k_reg     <= word_k_next;
            word_valid_reg <= word_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg         <= lo_next;
        word_index_reg <= word_index_next;
        word_value_reg <= word_value_next;
        last_word_reg  <= last_word_next;
    end

    assign word_valid = word_valid_reg;
    assign word_index = word_index_reg;
    assign word_value = word_value_reg;
    assign last_word  = last_word_reg;

    // The counter never reaches a full frame; the last byte returns it to hunting.
    assert property (@(posedge clk) disable iff (!rst_n)
        bytes_held_reg < swsfd_pkg::CNT_W'(swsfd_pkg::FRAME_BYTES))
        else $error("frame byte counter out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        rx_valid && !rx_stall && bytes_held_reg == swsfd_pkg::POS_END2
        |=> bytes_held_reg == '0)
        else $error("counter not cleared after last frame byte");

    assert property (@(posedge clk) disable iff (!rst_n)
        word_valid && last_word |-> word_index == swsfd_pkg::MODE_WORD)
        else $error("last result is not the mode byte");

    // A data word on the output means the mode byte of that frame is still to come.
    assert property (@(posedge clk) disable iff (!rst_n)
        word_valid && !last_word |-> state_reg != ST_IDLE)
        else $error("replay ended before the mode byte");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_IDLE |-> bytes_held_reg == '0)
        else $error("collecting bytes during replay");

endmodule
